>>> rtl/ecpr_pkg.sv
package ecpr_pkg;

  // Frames examined by the victim scanner in each cycle.
  localparam int SCAN_LANES = 16;

  // Value of the frame count register after reset.
  localparam logic [6:0] CFG_FRAMES_RESET = 7'd64;

  // Request codes.
  localparam logic CMD_FAULT = 1'b0;
  localparam logic CMD_TOUCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SELECT,
    ST_COMMIT
  } ecpr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan;
    logic select;
    logic commit;
  } ecpr_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic direct;
    logic scan_last;
  } ecpr_sts_t;

endpackage

>>> rtl/ecpr_ctrl.sv
module ecpr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ecpr_pkg::ecpr_sts_t sts,
  output ecpr_pkg::ecpr_ctl_t ctl
);
  import ecpr_pkg::*;

  ecpr_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State and output flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = sts.direct ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_SELECT;
        end
      end
      ST_SELECT: begin
        ctl.select = 1'b1;
        state_nxt  = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          ctl.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // A result is only written when the output register is free.
  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (!out_valid_r || out_ready))
    else $error("result written over a waiting result");

  // A new result only appears after a commit.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_COMMIT))
    else $error("result valid without commit");

  // A fault that needs a victim goes through the scanner.
  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.capture && !sts.direct) |=> (state_r == ST_SCAN))
    else $error("eviction request skipped the scan");

endmodule

>>> rtl/ecpr_dpath.sv
module ecpr_dpath #(
  parameter int FRAMES    = 64,
  parameter int PAGE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [6:0]          cfg_wr_data,
  input  logic                in_cmd,
  input  logic [15:0]         in_page_number,
  input  logic [5:0]          in_touch_frame,
  input  logic                in_ref_in,
  input  logic                in_dirty_in,
  input  ecpr_pkg::ecpr_ctl_t ctl,
  output ecpr_pkg::ecpr_sts_t sts,
  output logic [5:0]          out_frame_used,
  output logic                out_evicted,
  output logic [15:0]         out_evicted_page,
  output logic                out_write_back,
  output logic [31:0]         out_fault_total,
  output logic [31:0]         out_clear_total,
  output logic [31:0]         out_writeback_total
);
  import ecpr_pkg::*;

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int OFF_W = CMP_W + 1;

  // Persistent state.
  logic [6:0]           cfg_r;
  logic [FRAMES-1:0]    ref_r;
  logic [FRAMES-1:0]    dirty_r;
  logic [IDX_W-1:0]     hand_r;
  logic [CNT_W-1:0]     occ_r;
  logic [31:0]          faults_r;
  logic [31:0]          clears_r;
  logic [31:0]          wbs_r;
  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [PAGE_BITS-1:0] rd_data_r;

  // Request held for the duration of its processing.
  logic                 cmd_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [5:0]           tf_r;
  logic                 rin_r;
  logic                 din_r;
  logic [CNT_W-1:0]     n_r;
  logic [IDX_W-1:0]     start_r;
  logic                 fill_r;

  // Scanner state.
  logic [OFF_W-1:0]     k_r;
  logic                 f00_r, f01_r, f10_r;
  logic [IDX_W-1:0]     p00_r, p01_r, p10_r;
  logic [CNT_W-1:0]     o01_r;
  logic [IDX_W-1:0]     victim_r;

  // Output register.
  logic [5:0]           frame_used_r;
  logic                 evicted_r;
  logic [15:0]          evicted_page_r;
  logic                 write_back_r;
  logic [31:0]          fault_total_r;
  logic [31:0]          clear_total_r;
  logic [31:0]          wb_total_r;

  // Effective frame count and scan start from the current settings.
  logic [CMP_W-1:0] cfg_ext;
  logic [CMP_W-1:0] eff_w;
  logic [CNT_W-1:0] eff_n;
  logic [CNT_W-1:0] hand_p1;
  logic [IDX_W-1:0] start_w;

  always_comb begin
    cfg_ext = CMP_W'(cfg_r);
    if (cfg_ext == '0) begin
      eff_w = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(FRAMES)) begin
      eff_w = CMP_W'(FRAMES);
    end else begin
      eff_w = cfg_ext;
    end
    eff_n   = CNT_W'(eff_w);
    hand_p1 = CNT_W'(hand_r) + CNT_W'(1);
    if (CNT_W'(hand_r) >= eff_n || hand_p1 >= eff_n) begin
      start_w = '0;
    end else begin
      start_w = IDX_W'(hand_p1);
    end
    sts.direct    = (in_cmd == CMD_TOUCH) || (occ_r < eff_n);
    sts.scan_last = (k_r + OFF_W'(SCAN_LANES)) >= OFF_W'(n_r);
  end

  // One chunk of the circular scan: the first frame of each class in the chunk.
  logic [OFF_W-1:0] lane_off [SCAN_LANES];
  logic [OFF_W-1:0] lane_pos [SCAN_LANES];
  logic [SCAN_LANES-1:0] hit00, hit01, hit10;
  logic             c00, c01, c10;
  logic [IDX_W-1:0] c00_pos, c01_pos, c10_pos;
  logic [OFF_W-1:0] c01_off;

  always_comb begin
    for (int j = 0; j < SCAN_LANES; j++) begin
      lane_off[j] = k_r + OFF_W'(j);
      lane_pos[j] = OFF_W'(start_r) + lane_off[j];
      if (lane_pos[j] >= OFF_W'(n_r)) begin
        lane_pos[j] = lane_pos[j] - OFF_W'(n_r);
      end
      hit00[j] = (lane_off[j] < OFF_W'(n_r)) &&
                 !ref_r[lane_pos[j][IDX_W-1:0]] && !dirty_r[lane_pos[j][IDX_W-1:0]];
      hit01[j] = (lane_off[j] < OFF_W'(n_r)) &&
                 !ref_r[lane_pos[j][IDX_W-1:0]] && dirty_r[lane_pos[j][IDX_W-1:0]];
      hit10[j] = (lane_off[j] < OFF_W'(n_r)) &&
                 ref_r[lane_pos[j][IDX_W-1:0]] && !dirty_r[lane_pos[j][IDX_W-1:0]];
    end
    c00     = |hit00;
    c01     = |hit01;
    c10     = |hit10;
    c00_pos = '0;
    c01_pos = '0;
    c10_pos = '0;
    c01_off = '0;
    for (int j = SCAN_LANES - 1; j >= 0; j--) begin
      if (hit00[j]) begin
        c00_pos = lane_pos[j][IDX_W-1:0];
      end
      if (hit01[j]) begin
        c01_pos = lane_pos[j][IDX_W-1:0];
        c01_off = lane_off[j];
      end
      if (hit10[j]) begin
        c10_pos = lane_pos[j][IDX_W-1:0];
      end
    end
  end

  // Victim choice. Without a clean unreferenced frame, the frames skipped on the
  // way to the first dirty unreferenced one lose their reference bit. With no such
  // frame every managed reference bit is cleared and the clean ones come first.
  logic [IDX_W-1:0]  vsel;
  logic [CNT_W-1:0]  clear_add;
  logic              clear_range;
  logic              clear_all;
  logic [FRAMES-1:0] clear_mask;
  logic [32:0]       clears_sum;

  always_comb begin
    clear_range = 1'b0;
    clear_all   = 1'b0;
    if (f00_r) begin
      vsel      = p00_r;
      clear_add = '0;
    end else if (f01_r) begin
      vsel        = p01_r;
      clear_add   = o01_r;
      clear_range = 1'b1;
    end else if (f10_r) begin
      vsel      = p10_r;
      clear_add = n_r;
      clear_all = 1'b1;
    end else begin
      vsel      = start_r;
      clear_add = n_r;
      clear_all = 1'b1;
    end
    // A wrapping range stays inside the managed frames.
    for (int i = 0; i < FRAMES; i++) begin
      if (start_r <= vsel) begin
        clear_mask[i] = clear_range && (IDX_W'(i) >= start_r) && (IDX_W'(i) < vsel);
      end else begin
        clear_mask[i] = clear_range && (CNT_W'(i) < n_r) &&
                        ((IDX_W'(i) >= start_r) || (IDX_W'(i) < vsel));
      end
      if (clear_all && (CNT_W'(i) < n_r)) begin
        clear_mask[i] = 1'b1;
      end
    end
    clears_sum = {1'b0, clears_r} + 33'(clear_add);
  end

  // Effects of the commit step.
  logic             touch_ok;
  logic [IDX_W-1:0] touch_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             evict;
  logic             wb;
  logic [31:0]      faults_nxt;
  logic [31:0]      wbs_nxt;

  always_comb begin
    touch_ok  = (CMP_W'(tf_r) < CMP_W'(occ_r)) && (CMP_W'(tf_r) < CMP_W'(n_r));
    touch_idx = IDX_W'(tf_r);
    evict     = (cmd_r == CMD_FAULT) && !fill_r;
    wr_idx    = fill_r ? IDX_W'(occ_r) : victim_r;
    wb        = evict && dirty_r[victim_r];
    if (cmd_r == CMD_FAULT && faults_r != '1) begin
      faults_nxt = faults_r + 32'd1;
    end else begin
      faults_nxt = faults_r;
    end
    if (wb && wbs_r != '1) begin
      wbs_nxt = wbs_r + 32'd1;
    end else begin
      wbs_nxt = wbs_r;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_FRAMES_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // Request capture and scanner progress.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r   <= in_cmd;
      page_r  <= PAGE_BITS'(in_page_number);
      tf_r    <= in_touch_frame;
      rin_r   <= in_ref_in;
      din_r   <= in_dirty_in;
      n_r     <= eff_n;
      start_r <= start_w;
      fill_r  <= occ_r < eff_n;
      k_r     <= '0;
      f00_r   <= 1'b0;
      f01_r   <= 1'b0;
      f10_r   <= 1'b0;
    end else if (ctl.scan) begin
      k_r <= k_r + OFF_W'(SCAN_LANES);
      if (!f00_r && c00) begin
        f00_r <= 1'b1;
        p00_r <= c00_pos;
      end
      if (!f01_r && c01) begin
        f01_r <= 1'b1;
        p01_r <= c01_pos;
        o01_r <= CNT_W'(c01_off);
      end
      if (!f10_r && c10) begin
        f10_r <= 1'b1;
        p10_r <= c10_pos;
      end
    end
    if (ctl.select) begin
      victim_r <= vsel;
    end
  end

  // Page store: written on a fault commit, victim page read when the victim is chosen.
  always_ff @(posedge clk) begin
    if (ctl.commit && cmd_r == CMD_FAULT) begin
      page_mem[wr_idx] <= page_r;
    end
    if (ctl.select) begin
      rd_data_r <= page_mem[vsel];
    end
  end

  // Frame bits, hand, fill count and totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r    <= '0;
      dirty_r  <= '0;
      hand_r   <= '0;
      occ_r    <= '0;
      faults_r <= '0;
      clears_r <= '0;
      wbs_r    <= '0;
    end else if (ctl.select) begin
      ref_r    <= ref_r & ~clear_mask;
      clears_r <= clears_sum[32] ? 32'hFFFF_FFFF : clears_sum[31:0];
    end else if (ctl.commit) begin
      faults_r <= faults_nxt;
      wbs_r    <= wbs_nxt;
      if (cmd_r == CMD_TOUCH) begin
        if (touch_ok) begin
          ref_r[touch_idx]   <= ref_r[touch_idx] | rin_r;
          dirty_r[touch_idx] <= dirty_r[touch_idx] | din_r;
        end
      end else begin
        ref_r[wr_idx]   <= rin_r;
        dirty_r[wr_idx] <= din_r;
        if (fill_r) begin
          occ_r <= occ_r + CNT_W'(1);
        end else begin
          hand_r <= victim_r;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      frame_used_r   <= (cmd_r == CMD_TOUCH) ? tf_r : 6'(wr_idx);
      evicted_r      <= evict;
      evicted_page_r <= evict ? 16'(rd_data_r) : 16'd0;
      write_back_r   <= wb;
      fault_total_r  <= faults_nxt;
      clear_total_r  <= clears_r;
      wb_total_r     <= wbs_nxt;
    end
  end

  assign out_frame_used      = frame_used_r;
  assign out_evicted         = evicted_r;
  assign out_evicted_page    = evicted_page_r;
  assign out_write_back      = write_back_r;
  assign out_fault_total     = fault_total_r;
  assign out_clear_total     = clear_total_r;
  assign out_writeback_total = wb_total_r;

  // The chosen victim lies inside the managed frames.
  a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.select |=> (CNT_W'(victim_r) < n_r))
    else $error("victim outside managed frames");

  // The scanner only steps over offsets inside the managed frames.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scan |-> (k_r < OFF_W'(n_r)))
    else $error("scan beyond managed frames");

  // The fill count never passes the number of frames.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(FRAMES))
    else $error("fill count overflow");

endmodule

>>> rtl/enhanced_clock_page_replacer.sv
// Touch and fill requests go from acceptance straight to commit, which waits while
// an untaken result is held. Fault requests needing a victim go through scan, select
// and commit; the scanner examines 16 of the n managed frames per cycle.
// One request at a time; the next is accepted the cycle after the previous commits.
// Synchronous active-low reset clears reference/dirty bits, hand, fill count and
// totals and sets the frame count to 64; the page store is not cleared.
module enhanced_clock_page_replacer #(
  parameter int FRAMES    = 64,
  parameter int PAGE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_page_number,
  input  logic [5:0]  in_touch_frame,
  input  logic        in_ref_in,
  input  logic        in_dirty_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_frame_used,
  output logic        out_evicted,
  output logic [15:0] out_evicted_page,
  output logic        out_write_back,
  output logic [31:0] out_fault_total,
  output logic [31:0] out_clear_total,
  output logic [31:0] out_writeback_total
);
  import ecpr_pkg::*;

  ecpr_ctl_t ctl;
  ecpr_sts_t sts;

  // Sequencer.
  ecpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Frame state, scanner and result register.
  ecpr_dpath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_cmd              (in_cmd),
    .in_page_number      (in_page_number),
    .in_touch_frame      (in_touch_frame),
    .in_ref_in           (in_ref_in),
    .in_dirty_in         (in_dirty_in),
    .ctl                 (ctl),
    .sts                 (sts),
    .out_frame_used      (out_frame_used),
    .out_evicted         (out_evicted),
    .out_evicted_page    (out_evicted_page),
    .out_write_back      (out_write_back),
    .out_fault_total     (out_fault_total),
    .out_clear_total     (out_clear_total),
    .out_writeback_total (out_writeback_total)
  );

endmodule
